// File: design/json_nesting_emitter_top_defines.svh
// assertion macros for the asserting top-level file
`ifndef JSON_NESTING_EMITTER_TOP_DEFINES_SVH
`define JSON_NESTING_EMITTER_TOP_DEFINES_SVH

// implication in the same cycle, held off during reset
`define JNE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication in the next cycle, held off during reset
`define JNE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/jne_pkg.sv
package jne_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned RESULT_LIMIT    = 15;
  localparam int unsigned OP_W            = 4;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned LEN_W           = 3;
  localparam int unsigned IDX_W           = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ELEM_START   = 4'd0,
    OP_KEY_BYTE     = 4'd1,
    OP_KEY_END      = 4'd2,
    OP_OPEN_ARRAY   = 4'd3,
    OP_OPEN_OBJECT  = 4'd4,
    OP_OPEN_STRING  = 4'd5,
    OP_STRING_BYTE  = 4'd6,
    OP_CLOSE_ARRAY  = 4'd7,
    OP_CLOSE_OBJECT = 4'd8,
    OP_CLOSE_STRING = 4'd9,
    OP_LITERAL_BYTE = 4'd10,
    OP_CLOSE_ALL    = 4'd11
  } op_e;

  typedef enum logic [1:0] {
    KIND_ROOT   = 2'd0,
    KIND_ARRAY  = 2'd1,
    KIND_OBJECT = 2'd2,
    KIND_STRING = 2'd3
  } kind_e;

  localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_SOLIDUS   = 8'h2f;
  localparam logic [BYTE_W-1:0] CH_COMMA     = 8'h2c;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0] CH_COLON     = 8'h3a;
  localparam logic [BYTE_W-1:0] CH_LOWER_U   = 8'h75;
  localparam logic [BYTE_W-1:0] CH_ZERO      = 8'h30;
  localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5b;
  localparam logic [BYTE_W-1:0] CH_RBRACKET  = 8'h5d;
  localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7b;
  localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7d;
  localparam logic [BYTE_W-1:0] CTRL_MAX     = 8'h1f;

  // controller to datapath
  typedef struct packed {
    logic             accept;
    logic             emit;
    logic             pop;
    logic             load;
    logic [IDX_W-1:0] idx;
  } jne_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             close_all;
    logic             pop_item;
    logic             ca_done;
    logic             slot_free;
  } jne_stat_t;

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
    logic [BYTE_W-1:0] res;
    if (nib < 4'd10) begin
      res = CH_ZERO + {4'd0, nib};
    end else begin
      res = 8'h37 + {4'd0, nib};
    end
    return res;
  endfunction

  function automatic logic [BYTE_W-1:0] closer_of(input kind_e kind);
    logic [BYTE_W-1:0] res;
    case (kind)
      KIND_ARRAY:  res = CH_RBRACKET;
      KIND_OBJECT: res = CH_RBRACE;
      KIND_STRING: res = CH_QUOTE;
      default:     res = '0;
    endcase
    return res;
  endfunction

endpackage

// File: design/jne_if.sv
interface jne_in_if;
  import jne_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] data_byte;
  logic              has_key;

  modport source (output valid, output operation, output data_byte, output has_key,
                  input ready);
  modport sink (input valid, input operation, input data_byte, input has_key,
                output ready);
endinterface

interface jne_out_if;
  import jne_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              error;
  logic              last;

  modport source (output valid, output out_byte, output error, output last,
                  input ready);
  modport sink (input valid, input out_byte, input error, input last,
                output ready);
endinterface

// File: design/json_nesting_emitter_top.sv
// channel | dir | fields                          | transfer
// in_i    | in  | operation, data_byte, has_key   | valid && ready
// out_o   | out | out_byte, error, last           | valid && ready
//
// an item is taken in the idle state, then each result byte is loaded
// once the output register is free, and a final step finishes the item
// each closer pops the nesting stack memory and adds a load step for its
// registered read, so close_all emits and refills per level, up to 15 levels
// asynchronous active-low reset puts the stack at the root, no clearing pass
// a stalled output holds the result byte and the sequencer waits on it
`include "json_nesting_emitter_top_defines.svh"

module json_nesting_emitter_top import jne_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jne_in_if.sink    in_i,
  jne_out_if.source out_o
);

  jne_cmd_t  cmd;
  jne_stat_t stat;

  // controller: accepts items and steps through their result bytes
  jne_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: rule checks, nesting stack, escape sequencing, output register
  jne_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (in_i.operation),
    .byte_i      (in_i.data_byte),
    .key_i       (in_i.has_key),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_byte_o  (out_o.out_byte),
    .out_error_o (out_o.error),
    .out_last_o  (out_o.last)
  );

  // an error result is a lone zero byte that closes its item
  `JNE_ASSERT_NOW(a_err_lone, out_o.valid && out_o.error,
                  out_o.last && (out_o.out_byte == '0), "error result not lone zero byte")

  // every pop is followed by a refill of the cached top
  `JNE_ASSERT_NEXT(a_pop_load, cmd.pop, cmd.load && !cmd.emit, "pop without top refill")

  // no new item is taken while a result byte is being produced
  `JNE_ASSERT_NOW(a_no_overlap, cmd.emit, !in_i.ready, "item taken while emitting")

  // a result byte is only loaded into a free output register
  `JNE_ASSERT_NOW(a_slot_free, cmd.emit, !out_o.valid || out_o.ready,
                  "output register overwritten")

endmodule

// File: design/jne_ram.sv
module jne_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/jne_ctrl.sv
module jne_ctrl import jne_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  jne_stat_t stat_i,
  output jne_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EMIT = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.idx   = idx_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          idx_d        = '0;
          state_d      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.close_all) begin
          if (stat_i.ca_done) begin
            state_d = S_IDLE;
          end else if (stat_i.slot_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.pop  = 1'b1;
            idx_d      = idx_q + 1'b1;
            state_d    = S_LOAD;
          end
        end else if (idx_q == {1'b0, stat_i.len}) begin
          state_d = S_IDLE;
        end else if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          idx_d      = idx_q + 1'b1;
          if (stat_i.pop_item) begin
            cmd_o.pop = 1'b1;
            state_d   = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        // refill the cached top from the stack memory
        cmd_o.load = 1'b1;
        state_d    = S_EMIT;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// File: design/jne_dp.sv
module jne_dp import jne_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [OP_W-1:0]   op_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic              key_i,
  input  jne_cmd_t          cmd_i,
  output jne_stat_t         stat_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_error_o,
  output logic              out_last_o
);

  localparam int unsigned DW = $clog2(STACK_DEPTH);
  localparam logic [DW-1:0] DP_MAX = DW'(STACK_DEPTH - 1);

  function automatic logic is_ctrl(input logic [BYTE_W-1:0] c);
    return c <= CTRL_MAX;
  endfunction

  function automatic logic is_special(input logic [BYTE_W-1:0] c);
    return (c == CH_QUOTE) || (c == CH_BACKSLASH) || (c == CH_SOLIDUS);
  endfunction

  function automatic logic [LEN_W-1:0] esc_len(input logic [BYTE_W-1:0] c);
    logic [LEN_W-1:0] res;
    if (is_ctrl(c)) begin
      res = 3'd6;
    end else if (is_special(c)) begin
      res = 3'd2;
    end else begin
      res = 3'd1;
    end
    return res;
  endfunction

  op_e               in_op;
  logic              err_d, err_q;
  logic [LEN_W-1:0]  len_d, len_q;
  logic              push;
  kind_e             push_kind;

  kind_e             top_kind_q;
  logic              top_ne_q;
  logic [DW-1:0]     dp_q;

  op_e               op_q;
  logic [BYTE_W-1:0] byte_q;
  logic              ne_q;

  logic [2:0]        ram_rdata;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_last;
  logic              ca_last;

  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_error_q;
  logic              out_last_q;

  assign in_op = op_e'(op_i);

  // rule check and result count of an incoming item
  always_comb begin
    err_d     = 1'b0;
    len_d     = '0;
    push      = 1'b0;
    push_kind = KIND_ARRAY;
    case (in_op)
      OP_ELEM_START: begin
        err_d = (top_kind_q == KIND_STRING) || (key_i != (top_kind_q == KIND_OBJECT));
        len_d = {1'b0, top_ne_q, key_i};
      end
      OP_KEY_BYTE: begin
        err_d = top_kind_q != KIND_OBJECT;
        len_d = esc_len(byte_i);
      end
      OP_KEY_END: begin
        err_d = top_kind_q != KIND_OBJECT;
        len_d = 3'd3;
      end
      OP_OPEN_ARRAY: begin
        err_d = dp_q == DP_MAX;
        len_d = 3'd1;
        push  = 1'b1;
      end
      OP_OPEN_OBJECT: begin
        err_d     = dp_q == DP_MAX;
        len_d     = 3'd1;
        push      = 1'b1;
        push_kind = KIND_OBJECT;
      end
      OP_OPEN_STRING: begin
        err_d     = dp_q == DP_MAX;
        len_d     = 3'd1;
        push      = 1'b1;
        push_kind = KIND_STRING;
      end
      OP_STRING_BYTE: begin
        err_d = top_kind_q != KIND_STRING;
        len_d = esc_len(byte_i);
      end
      OP_CLOSE_ARRAY: begin
        err_d = (dp_q == '0) || (top_kind_q != KIND_ARRAY);
        len_d = 3'd1;
      end
      OP_CLOSE_OBJECT: begin
        err_d = (dp_q == '0) || (top_kind_q != KIND_OBJECT);
        len_d = 3'd1;
      end
      OP_CLOSE_STRING: begin
        err_d = (dp_q == '0) || (top_kind_q != KIND_STRING);
        len_d = 3'd1;
      end
      OP_LITERAL_BYTE: begin
        len_d = 3'd1;
      end
      default: begin
        len_d = '0;
      end
    endcase
    if (err_d) begin
      len_d = 3'd1;
    end
  end

  // levels below the top live in memory, the top is cached in flops
  jne_ram #(
    .WIDTH (3),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && push && !err_d),
    .waddr_i (dp_q),
    .wdata_i ({top_kind_q, top_ne_q}),
    .raddr_i (dp_q - 1'b1),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_kind_q <= KIND_ROOT;
      top_ne_q   <= 1'b0;
      dp_q       <= '0;
      err_q      <= 1'b0;
      len_q      <= '0;
      op_q       <= OP_LITERAL_BYTE;
    end else begin
      if (cmd_i.accept) begin
        err_q <= err_d;
        len_q <= len_d;
        op_q  <= in_op;
        if (!err_d && (in_op == OP_ELEM_START)) begin
          top_ne_q <= 1'b1;
        end
        if (!err_d && push) begin
          top_kind_q <= push_kind;
          top_ne_q   <= 1'b0;
          dp_q       <= dp_q + 1'b1;
        end
      end
      if (cmd_i.pop) begin
        dp_q <= dp_q - 1'b1;
      end
      if (cmd_i.load) begin
        top_kind_q <= kind_e'(ram_rdata[2:1]);
        top_ne_q   <= ram_rdata[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= byte_i;
      ne_q   <= top_ne_q;
    end
  end

  // byte at the current result index
  always_comb begin
    emit_byte = '0;
    case (op_q)
      OP_ELEM_START: begin
        if (ne_q && (cmd_i.idx == 4'd0)) begin
          emit_byte = CH_COMMA;
        end else if (ne_q && (cmd_i.idx == 4'd1)) begin
          emit_byte = CH_SPACE;
        end else begin
          emit_byte = CH_QUOTE;
        end
      end
      OP_KEY_BYTE, OP_STRING_BYTE: begin
        if (is_ctrl(byte_q)) begin
          case (cmd_i.idx)
            4'd0:    emit_byte = CH_BACKSLASH;
            4'd1:    emit_byte = CH_LOWER_U;
            4'd4:    emit_byte = hex_digit({3'd0, byte_q[4]});
            4'd5:    emit_byte = hex_digit(byte_q[3:0]);
            default: emit_byte = CH_ZERO;
          endcase
        end else if (is_special(byte_q) && (cmd_i.idx == 4'd0)) begin
          emit_byte = CH_BACKSLASH;
        end else begin
          emit_byte = byte_q;
        end
      end
      OP_KEY_END: begin
        case (cmd_i.idx)
          4'd0:    emit_byte = CH_QUOTE;
          4'd1:    emit_byte = CH_COLON;
          default: emit_byte = CH_SPACE;
        endcase
      end
      OP_OPEN_ARRAY:   emit_byte = CH_LBRACKET;
      OP_OPEN_OBJECT:  emit_byte = CH_LBRACE;
      OP_OPEN_STRING:  emit_byte = CH_QUOTE;
      OP_CLOSE_ARRAY:  emit_byte = CH_RBRACKET;
      OP_CLOSE_OBJECT: emit_byte = CH_RBRACE;
      OP_CLOSE_STRING: emit_byte = CH_QUOTE;
      OP_LITERAL_BYTE: emit_byte = byte_q;
      OP_CLOSE_ALL:    emit_byte = closer_of(top_kind_q);
      default:         emit_byte = '0;
    endcase
    if (err_q) begin
      emit_byte = '0;
    end
  end

  assign ca_last   = (dp_q == DW'(1)) || (cmd_i.idx == IDX_W'(RESULT_LIMIT - 1));
  assign emit_last = (op_q == OP_CLOSE_ALL) ? ca_last
                   : (cmd_i.idx == ({1'b0, len_q} - IDX_W'(1)));

  always_comb begin
    stat_o           = '0;
    stat_o.len       = len_q;
    stat_o.close_all = op_q == OP_CLOSE_ALL;
    stat_o.pop_item  = !err_q && ((op_q == OP_CLOSE_ARRAY) || (op_q == OP_CLOSE_OBJECT) ||
                                  (op_q == OP_CLOSE_STRING));
    stat_o.ca_done   = (dp_q == '0) || (cmd_i.idx == IDX_W'(RESULT_LIMIT));
    stat_o.slot_free = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q  <= emit_byte;
      out_error_q <= err_q;
      out_last_q  <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_error_o = out_error_q;
  assign out_last_o  = out_last_q;

endmodule
